[rtl/sst_pkg.sv]
package sst_pkg;

    // request codes carried by req_type
    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_CLEAR  = 2'd2,
        REQ_READ   = 2'd3
    } req_t;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_FULL       = 3'd1,
        ST_TOO_LONG   = 3'd2,
        ST_DUP        = 3'd3,
        ST_NOT_FOUND  = 3'd4,
        ST_RANK_RANGE = 3'd5
    } status_t;

    // configuration register indexes
    localparam logic [1:0] CFG_ENTRIES   = 2'd0;
    localparam logic [1:0] CFG_ENTRY_LEN = 2'd1;
    localparam logic [1:0] CFG_ALLOW_DUP = 2'd2;

    // most characters returned by one read
    localparam int RESULT_CAP = 30;

    // commands from controller to datapath
    typedef struct packed {
        logic    accept_rank;
        logic    pend_push;
        logic    pend_clr;
        logic    full_clr_all;
        logic    idx_clr;
        logic    idx_inc;
        logic    seen_clr;
        logic    seen_inc;
        logic    tgt_cap;
        logic    k_clr;
        logic    k_inc;
        logic    n_cap;
        logic    use_tgt;
        logic    len_rd;
        logic    chr_rd;
        logic    chr_wr;
        logic    len_wr;
        logic    set_full;
        logic    unset_full;
        logic    rem_clr;
        logic    out_load;
        logic    out_slot_tgt;
        logic    out_char_mem;
        logic    out_last;
        status_t out_status;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic idx_full;
        logic idx_last;
        logic idx_in_lim;
        logic too_long;
        logic dup_ok;
        logic len_eq;
        logic pend_zero;
        logic chr_eq;
        logic k_last_cmp;
        logic k_done;
        logic seen_eq;
        logic rlen_zero;
        logic emit_last;
        logic out_free;
        logic any_removed;
    } stat_t;

endpackage

[rtl/sst_ctrl.sv]
module sst_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [1:0]     req_type,
    input  logic           last_char,
    input  sst_pkg::stat_t st,
    output sst_pkg::cmd_t  cmd
);
    import sst_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RESP,
        S_FSCAN,
        S_CLEN,
        S_CLCHK,
        S_CRD,
        S_CCHK,
        S_NXT,
        S_COPY,
        S_COMMIT,
        S_RSCAN,
        S_RLEN,
        S_RLCHK,
        S_RRD,
        S_RPUT
    } state_t;

    state_t  state_reg, state_next;
    logic    is_add_reg, is_add_next;
    logic    pclr_reg, pclr_next;
    logic    resp_tgt_reg, resp_tgt_next;
    status_t resp_status_reg, resp_status_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            is_add_reg      <= 1'b0;
            pclr_reg        <= 1'b0;
            resp_tgt_reg    <= 1'b0;
            resp_status_reg <= ST_OK;
        end
        else
        begin
            state_reg       <= state_next;
            is_add_reg      <= is_add_next;
            pclr_reg        <= pclr_next;
            resp_tgt_reg    <= resp_tgt_next;
            resp_status_reg <= resp_status_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd              = '0;
        cmd.out_status   = ST_OK;
        state_next       = state_reg;
        is_add_next      = is_add_reg;
        pclr_next        = pclr_reg;
        resp_tgt_next    = resp_tgt_reg;
        resp_status_next = resp_status_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (req_type)
                        REQ_CLEAR:
                        begin
                            cmd.full_clr_all = 1'b1;
                            resp_status_next = ST_OK;
                            resp_tgt_next    = 1'b0;
                            pclr_next        = 1'b0;
                            state_next       = S_RESP;
                        end
                        REQ_READ:
                        begin
                            cmd.accept_rank = 1'b1;
                            cmd.idx_clr     = 1'b1;
                            cmd.seen_clr    = 1'b1;
                            pclr_next       = 1'b0;
                            state_next      = S_RSCAN;
                        end
                        default:
                        begin
                            cmd.pend_push = 1'b1;
                            if (last_char)
                            begin
                                cmd.idx_clr = 1'b1;
                                pclr_next   = 1'b1;
                                is_add_next = (req_type == REQ_ADD);
                                if (req_type == REQ_ADD)
                                begin
                                    state_next = S_FSCAN;
                                end
                                else
                                begin
                                    cmd.rem_clr = 1'b1;
                                    state_next  = S_CLEN;
                                end
                            end
                        end
                    endcase
                end
            end

            S_RESP:
            begin
                if (st.out_free)
                begin
                    cmd.out_load     = 1'b1;
                    cmd.out_status   = resp_status_reg;
                    cmd.out_slot_tgt = resp_tgt_reg;
                    cmd.out_last     = 1'b1;
                    cmd.pend_clr     = pclr_reg;
                    state_next       = S_IDLE;
                end
            end

            // lowest free slot below the limit
            S_FSCAN:
            begin
                if (!st.idx_in_lim)
                begin
                    resp_status_next = ST_FULL;
                    resp_tgt_next    = 1'b0;
                    state_next       = S_RESP;
                end
                else if (!st.idx_full)
                begin
                    cmd.tgt_cap = 1'b1;
                    if (st.too_long)
                    begin
                        resp_status_next = ST_TOO_LONG;
                        resp_tgt_next    = 1'b0;
                        state_next       = S_RESP;
                    end
                    else if (st.dup_ok)
                    begin
                        cmd.k_clr  = 1'b1;
                        state_next = S_COPY;
                    end
                    else
                    begin
                        cmd.idx_clr = 1'b1;
                        state_next  = S_CLEN;
                    end
                end
                else if (st.idx_last)
                begin
                    resp_status_next = ST_FULL;
                    resp_tgt_next    = 1'b0;
                    state_next       = S_RESP;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end

            S_CLEN:
            begin
                cmd.len_rd = 1'b1;
                state_next = S_CLCHK;
            end

            S_CLCHK:
            begin
                if (st.idx_full && st.len_eq)
                begin
                    if (st.pend_zero)
                    begin
                        if (is_add_reg)
                        begin
                            resp_status_next = ST_DUP;
                            resp_tgt_next    = 1'b0;
                            state_next       = S_RESP;
                        end
                        else
                        begin
                            cmd.unset_full = 1'b1;
                            state_next     = S_NXT;
                        end
                    end
                    else
                    begin
                        cmd.k_clr  = 1'b1;
                        state_next = S_CRD;
                    end
                end
                else
                begin
                    state_next = S_NXT;
                end
            end

            S_CRD:
            begin
                cmd.chr_rd = 1'b1;
                state_next = S_CCHK;
            end

            S_CCHK:
            begin
                if (!st.chr_eq)
                begin
                    state_next = S_NXT;
                end
                else if (st.k_last_cmp)
                begin
                    if (is_add_reg)
                    begin
                        resp_status_next = ST_DUP;
                        resp_tgt_next    = 1'b0;
                        state_next       = S_RESP;
                    end
                    else
                    begin
                        cmd.unset_full = 1'b1;
                        state_next     = S_NXT;
                    end
                end
                else
                begin
                    cmd.k_inc  = 1'b1;
                    state_next = S_CRD;
                end
            end

            S_NXT:
            begin
                if (st.idx_last)
                begin
                    if (is_add_reg)
                    begin
                        cmd.k_clr  = 1'b1;
                        state_next = S_COPY;
                    end
                    else
                    begin
                        resp_status_next = st.any_removed ? ST_OK : ST_NOT_FOUND;
                        resp_tgt_next    = 1'b0;
                        state_next       = S_RESP;
                    end
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_CLEN;
                end
            end

            S_COPY:
            begin
                cmd.use_tgt = 1'b1;
                if (st.k_done)
                begin
                    state_next = S_COMMIT;
                end
                else
                begin
                    cmd.chr_wr = 1'b1;
                    cmd.k_inc  = 1'b1;
                end
            end

            S_COMMIT:
            begin
                cmd.use_tgt      = 1'b1;
                cmd.len_wr       = 1'b1;
                cmd.set_full     = 1'b1;
                resp_status_next = ST_OK;
                resp_tgt_next    = 1'b1;
                state_next       = S_RESP;
            end

            // rank-th full slot
            S_RSCAN:
            begin
                if (st.idx_full && st.seen_eq)
                begin
                    cmd.tgt_cap = 1'b1;
                    state_next  = S_RLEN;
                end
                else
                begin
                    cmd.seen_inc = st.idx_full;
                    if (st.idx_last)
                    begin
                        resp_status_next = ST_RANK_RANGE;
                        resp_tgt_next    = 1'b0;
                        state_next       = S_RESP;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                    end
                end
            end

            S_RLEN:
            begin
                cmd.use_tgt = 1'b1;
                cmd.len_rd  = 1'b1;
                state_next  = S_RLCHK;
            end

            S_RLCHK:
            begin
                cmd.n_cap = 1'b1;
                cmd.k_clr = 1'b1;
                if (st.rlen_zero)
                begin
                    resp_status_next = ST_OK;
                    resp_tgt_next    = 1'b1;
                    state_next       = S_RESP;
                end
                else
                begin
                    state_next = S_RRD;
                end
            end

            S_RRD:
            begin
                cmd.use_tgt = 1'b1;
                cmd.chr_rd  = 1'b1;
                state_next  = S_RPUT;
            end

            S_RPUT:
            begin
                if (st.out_free)
                begin
                    cmd.out_load     = 1'b1;
                    cmd.out_char_mem = 1'b1;
                    cmd.out_slot_tgt = 1'b1;
                    cmd.out_last     = st.emit_last;
                    cmd.out_status   = ST_OK;
                    cmd.k_inc        = 1'b1;
                    state_next       = st.emit_last ? S_IDLE : S_RRD;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/sst_dp.sv]
module sst_dp #(
    parameter int N = 64,
    parameter int L = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [7:0]                          char_code,
    input  logic [((N > 1) ? $clog2(N) : 1)-1:0] rank,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [1:0]                          cfg_index,
    input  logic [6:0]                          cfg_data,
    input  sst_pkg::cmd_t                       cmd,
    output sst_pkg::stat_t                      st,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [7:0]                          char_out,
    output logic                                last,
    output logic [2:0]                          status,
    output logic [$clog2(N+1)-1:0]              slot,
    output logic [$clog2(N+1)-1:0]              entry_count
);
    import sst_pkg::*;

    localparam int IW  = (N > 1) ? $clog2(N) : 1;
    localparam int SW  = $clog2(N + 1);
    localparam int PW  = $clog2(L + 1);
    localparam int KIW = $clog2(L);
    localparam int AW  = $clog2(N * L);

    // configuration
    logic [6:0]    ent_lim_reg;
    logic [5:0]    len_lim_reg;
    logic          dup_ok_reg;

    // pending string
    logic [7:0]    pend_reg [L];
    logic [PW-1:0] pend_len_reg;
    logic          pend_long_reg;

    // slot state
    logic [N-1:0]  full_reg;
    logic [SW-1:0] count_reg;
    logic          any_rem_reg;

    // scan counters
    logic [IW-1:0] idx_reg;
    logic [IW-1:0] seen_reg;
    logic [IW-1:0] rank_reg;
    logic [IW-1:0] tgt_reg;
    logic [PW-1:0] k_reg;
    logic [PW-1:0] n_reg;

    // stores
    logic [7:0]    cmem [N * L];
    logic [7:0]    cmem_rd_reg;
    logic [PW-1:0] lmem [N];
    logic [PW-1:0] lmem_rd_reg;

    // result register
    logic          out_valid_reg;
    logic [7:0]    out_char_reg;
    logic          out_last_reg;
    status_t       out_status_reg;
    logic [SW-1:0] out_slot_reg;
    logic [SW-1:0] out_count_reg;

    logic [IW-1:0] base;
    logic [AW-1:0] addr;
    logic [31:0]   len_cap;
    logic [31:0]   max_len;
    logic          pend_room;

    assign base      = cmd.use_tgt ? tgt_reg : idx_reg;
    assign addr      = AW'(base) * AW'(L) + AW'(k_reg);
    assign len_cap   = (32'(len_lim_reg) < 32'(L)) ? 32'(len_lim_reg) : 32'(L);
    assign max_len   = (len_cap >= 32'd2) ? (len_cap - 32'd2) : 32'd0;
    assign pend_room = (32'(pend_len_reg) < 32'(L));

    assign st.idx_full    = full_reg[idx_reg];
    assign st.idx_last    = (32'(idx_reg) == 32'(N - 1));
    assign st.idx_in_lim  = (32'(idx_reg) < 32'(ent_lim_reg));
    assign st.too_long    = pend_long_reg || (32'(pend_len_reg) > max_len);
    assign st.dup_ok      = dup_ok_reg;
    assign st.len_eq      = (lmem_rd_reg == pend_len_reg) && !pend_long_reg;
    assign st.pend_zero   = (pend_len_reg == '0);
    assign st.chr_eq      = (cmem_rd_reg == pend_reg[k_reg[KIW-1:0]]);
    assign st.k_last_cmp  = ((32'(k_reg) + 32'd1) == 32'(pend_len_reg));
    assign st.k_done      = (k_reg == pend_len_reg);
    assign st.seen_eq     = (seen_reg == rank_reg);
    assign st.rlen_zero   = (lmem_rd_reg == '0);
    assign st.emit_last   = ((32'(k_reg) + 32'd1) == 32'(n_reg));
    assign st.out_free    = !out_valid_reg || out_ready;
    assign st.any_removed = any_rem_reg;

    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign char_out    = out_char_reg;
    assign last        = out_last_reg;
    assign status      = out_status_reg;
    assign slot        = out_slot_reg;
    assign entry_count = out_count_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_lim_reg   <= 7'd64;
            len_lim_reg   <= 6'd32;
            dup_ok_reg    <= 1'b0;
            pend_len_reg  <= '0;
            pend_long_reg <= 1'b0;
            full_reg      <= '0;
            count_reg     <= '0;
            any_rem_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_ENTRIES:   ent_lim_reg <= cfg_data;
                    CFG_ENTRY_LEN: len_lim_reg <= cfg_data[5:0];
                    CFG_ALLOW_DUP: dup_ok_reg  <= cfg_data[0];
                    default:       ;
                endcase
            end

            if (cmd.pend_clr)
            begin
                pend_len_reg  <= '0;
                pend_long_reg <= 1'b0;
            end
            else if (cmd.pend_push)
            begin
                if (pend_room)
                begin
                    pend_len_reg <= pend_len_reg + PW'(1);
                end
                else
                begin
                    pend_long_reg <= 1'b1;
                end
            end

            if (cmd.full_clr_all)
            begin
                full_reg  <= '0;
                count_reg <= '0;
            end
            else if (cmd.set_full)
            begin
                full_reg[tgt_reg] <= 1'b1;
                count_reg         <= count_reg + SW'(1);
            end
            else if (cmd.unset_full)
            begin
                full_reg[idx_reg] <= 1'b0;
                count_reg         <= count_reg - SW'(1);
            end

            if (cmd.rem_clr)
            begin
                any_rem_reg <= 1'b0;
            end
            else if (cmd.unset_full)
            begin
                any_rem_reg <= 1'b1;
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // counters and payload
    always_ff @(posedge clk)
    begin
        if (cmd.pend_push && pend_room)
        begin
            pend_reg[pend_len_reg[KIW-1:0]] <= char_code;
        end
        if (cmd.accept_rank)
        begin
            rank_reg <= rank;
        end

        if (cmd.idx_clr)
        begin
            idx_reg <= '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_reg <= idx_reg + IW'(1);
        end

        if (cmd.seen_clr)
        begin
            seen_reg <= '0;
        end
        else if (cmd.seen_inc)
        begin
            seen_reg <= seen_reg + IW'(1);
        end

        if (cmd.tgt_cap)
        begin
            tgt_reg <= idx_reg;
        end

        if (cmd.k_clr)
        begin
            k_reg <= '0;
        end
        else if (cmd.k_inc)
        begin
            k_reg <= k_reg + PW'(1);
        end

        if (cmd.n_cap)
        begin
            n_reg <= (32'(lmem_rd_reg) > 32'(RESULT_CAP)) ? PW'(RESULT_CAP) : lmem_rd_reg;
        end

        if (cmd.out_load)
        begin
            out_char_reg   <= cmd.out_char_mem ? cmem_rd_reg : 8'd0;
            out_last_reg   <= cmd.out_last;
            out_status_reg <= cmd.out_status;
            out_slot_reg   <= cmd.out_slot_tgt ? SW'(tgt_reg) : SW'(N);
            out_count_reg  <= count_reg;
        end
    end

    // character store
    always_ff @(posedge clk)
    begin
        if (cmd.chr_wr)
        begin
            cmem[addr] <= pend_reg[k_reg[KIW-1:0]];
        end
        if (cmd.chr_rd)
        begin
            cmem_rd_reg <= cmem[addr];
        end
    end

    // length store
    always_ff @(posedge clk)
    begin
        if (cmd.len_wr)
        begin
            lmem[tgt_reg] <= pend_len_reg;
        end
        if (cmd.len_rd)
        begin
            lmem_rd_reg <= lmem[base];
        end
    end

endmodule

[rtl/string_set_table.sv]
// slotted string table: MAX_ENTRIES slots of MAX_ENTRY_LEN characters, each
// slot free or full. add and remove strings come in one character per word,
// the final one flagged by last_char; only that final word gives a result,
// and its req_type picks add or remove. a read by rank scans the slots for
// the rank-th full one and returns its characters (at most 30 words). a
// remove walks every slot in turn through the single-port length and
// character stores, comparing characters on slots of equal length; an add
// first scans for the lowest free slot, walks every slot in the same way
// unless duplicates are allowed, and ends by copying the characters. one
// request is worked on at a time, but the next word is taken while the
// previous result still sits in the output register. the stores need no
// clearing after reset: the full bits are flip-flops cleared by reset, and
// only the contents of full slots are ever used. configuration writes are
// taken at any time and must only be made while the table is idle
module string_set_table #(
    parameter int MAX_ENTRIES   = 64,
    parameter int MAX_ENTRY_LEN = 32
) (
    input  logic                                                  clk,
    input  logic                                                  rst_n,
    // request words
    input  logic                                                  in_valid,
    output logic                                                  in_ready,
    input  logic [1:0]                                            req_type,
    input  logic [7:0]                                            char_code,
    input  logic                                                  last_char,
    input  logic [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)-1:0] rank,
    // configuration writes
    input  logic                                                  cfg_valid,
    output logic                                                  cfg_ready,
    input  logic [1:0]                                            cfg_index,
    input  logic [6:0]                                            cfg_data,
    // result words
    output logic                                                  out_valid,
    input  logic                                                  out_ready,
    output logic [7:0]                                            char_out,
    output logic                                                  last,
    output logic [2:0]                                            status,
    output logic [$clog2(MAX_ENTRIES+1)-1:0]                      slot,
    output logic [$clog2(MAX_ENTRIES+1)-1:0]                      entry_count
);
    import sst_pkg::*;

    // command and status bundles between sequencer and datapath
    cmd_t  cmd;
    stat_t st;

    // sequencer: decodes each word and steps through the slot scans
    sst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .last_char (last_char),
        .st        (st),
        .cmd       (cmd)
    );

    // datapath: pending string, full bits, stores and the result register
    sst_dp #(
        .N (MAX_ENTRIES),
        .L (MAX_ENTRY_LEN)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_code   (char_code),
        .rank        (rank),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .st          (st),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .char_out    (char_out),
        .last        (last),
        .status      (status),
        .slot        (slot),
        .entry_count (entry_count)
    );

endmodule

[sim/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sst_pkg::*;

    localparam int NSLOT  = 64;
    localparam int SLEN   = 32;
    localparam logic [6:0] NONE = 7'd64;

    // one result word
    typedef struct packed {
        logic [7:0] chr;
        logic       lst;
        logic [2:0] st;
        logic [6:0] sl;
        logic [6:0] cnt;
    } res_t;

    // scoreboard: mirror of the table, queue of expected result words
    class table_board;
        bit           full_q [NSLOT];
        logic [7:0]   text   [NSLOT][SLEN];
        int           len_q  [NSLOT];
        int           count;
        logic [7:0]   pend   [SLEN];
        int           pend_n;
        bit           pend_over;
        int           lim_slots;
        int           lim_len;
        bit           dup_ok;
        res_t         awaited [$];
        int           errors;

        function new();
            foreach (full_q[i]) full_q[i] = 0;
            count = 0; pend_n = 0; pend_over = 0;
            lim_slots = 64; lim_len = 32; dup_ok = 0; errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [6:0] val);
            if (idx == CFG_ENTRIES) lim_slots = val;
            else if (idx == CFG_ENTRY_LEN) lim_len = val[5:0];
            else if (idx == CFG_ALLOW_DUP) dup_ok = val[0];
        endfunction

        function bit same(int s);
            if (!full_q[s] || pend_over || len_q[s] != pend_n) return 0;
            for (int k = 0; k < pend_n; k++)
                if (text[s][k] !== pend[k]) return 0;
            return 1;
        endfunction

        function void push(logic [7:0] c, logic l, logic [6:0] s, status_t st);
            res_t r;
            r.chr = c; r.lst = l; r.st = st; r.sl = s; r.cnt = count[6:0];
            awaited.push_back(r);
        endfunction

        // note one accepted request word and queue what it causes
        function void note_word(req_t rq, logic [7:0] c, logic lc, logic [5:0] rk);
            int fs, seen, n, maxl, removed, hit;
            status_t st;
            fs = NSLOT; hit = NSLOT; seen = 0; removed = 0;
            if (rq == REQ_CLEAR) begin
                foreach (full_q[i]) full_q[i] = 0;
                count = 0;
                push(8'd0, 1'b1, NONE, ST_OK);
                return;
            end
            if (rq == REQ_READ) begin
                for (int i = 0; i < NSLOT; i++)
                    if (full_q[i]) begin
                        if (seen == rk) begin hit = i; break; end
                        seen++;
                    end
                if (hit == NSLOT) begin
                    push(8'd0, 1'b1, NONE, ST_RANK_RANGE);
                    return;
                end
                n = len_q[hit] > RESULT_CAP ? RESULT_CAP : len_q[hit];
                if (n == 0) push(8'd0, 1'b1, hit[6:0], ST_OK);
                for (int k = 0; k < n; k++)
                    push(text[hit][k], k + 1 == n, hit[6:0], ST_OK);
                return;
            end
            if (pend_n < SLEN) pend[pend_n++] = c;
            else pend_over = 1;
            if (!lc) return;
            if (rq == REQ_ADD) begin
                maxl = (lim_len > SLEN ? SLEN : lim_len);
                maxl = maxl >= 2 ? maxl - 2 : 0;
                for (int i = 0; i < (lim_slots > NSLOT ? NSLOT : lim_slots); i++)
                    if (!full_q[i]) begin fs = i; break; end
                if (fs == NSLOT) st = ST_FULL;
                else if (pend_over || pend_n > maxl) st = ST_TOO_LONG;
                else begin
                    st = ST_OK;
                    if (!dup_ok)
                        for (int i = 0; i < NSLOT; i++)
                            if (same(i)) st = ST_DUP;
                end
                if (st == ST_OK) begin
                    for (int k = 0; k < pend_n; k++) text[fs][k] = pend[k];
                    len_q[fs] = pend_n; full_q[fs] = 1; count++;
                end else fs = NSLOT;
                pend_n = 0; pend_over = 0;
                push(8'd0, 1'b1, fs[6:0], st);
            end else begin
                for (int i = 0; i < NSLOT; i++)
                    if (same(i)) begin full_q[i] = 0; removed++; end
                count -= removed;
                pend_n = 0; pend_over = 0;
                push(8'd0, 1'b1, NONE, removed ? ST_OK : ST_NOT_FOUND);
            end
        endfunction

        // compare one accepted result word with the oldest expectation
        function void check_word(res_t got);
            res_t w;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            w = awaited.pop_front();
            if (got.chr !== w.chr) begin
                $display("%0t: char_out exp %h got %h", $time, w.chr, got.chr); errors++;
            end
            if (got.lst !== w.lst) begin
                $display("%0t: last exp %h got %h", $time, w.lst, got.lst); errors++;
            end
            if (got.st !== w.st) begin
                $display("%0t: status exp %0d got %0d", $time, w.st, got.st); errors++;
            end
            if (got.sl !== w.sl) begin
                $display("%0t: slot exp %0d got %0d", $time, w.sl, got.sl); errors++;
            end
            if (got.cnt !== w.cnt) begin
                $display("%0t: entry_count exp %0d got %0d", $time, w.cnt, got.cnt);
                errors++;
            end
        endfunction
    endclass

    logic       clk, rst_n;
    logic       in_valid, in_ready, last_char;
    logic [1:0] req_type;
    logic [7:0] char_code;
    logic [5:0] rank;
    logic       cfg_valid, cfg_ready;
    logic [1:0] cfg_index;
    logic [6:0] cfg_data;
    logic       out_valid, out_ready, last;
    logic [7:0] char_out;
    logic [2:0] status;
    logic [6:0] slot, entry_count;

    table_board board;
    bit         calm;       // no idling on either side while set
    int         words_sent;

    string_set_table dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .req_type(req_type),
        .char_code(char_code), .last_char(last_char), .rank(rank),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .out_valid(out_valid), .out_ready(out_ready), .char_out(char_out),
        .last(last), .status(status), .slot(slot), .entry_count(entry_count)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // safety limit, far above the slowest correct run
    initial
    begin
        #20ms;
        $display("tb NOT OK");
        $finish;
    end

    // result side: random stalls, every accepted word checked
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (out_valid && out_ready)
                board.check_word({char_out, last, status, slot, entry_count});
            out_ready <= calm || ($urandom_range(99) >= 6);
        end
    end

    // send one request word, holding it until taken; valid stays up for the
    // next word unless the sender idles or drains
    task automatic send_word(req_t rq, logic [7:0] c, logic lc, logic [5:0] rk);
        bit idle;
        idle = !calm && ($urandom_range(99) < 6);
        while (idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
            idle = ($urandom_range(99) < 6);
        end
        in_valid  <= 1'b1;
        req_type  <= rq;
        char_code <= c;
        last_char <= lc;
        rank      <= rk;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        board.note_word(rq, c, lc, rk);
        words_sent++;
    endtask

    // a whole add or remove string
    task automatic send_string(req_t rq, int n, int alpha);
        for (int k = 0; k < n; k++)
            send_word(rq, (alpha == 0) ? 8'($urandom) : 8'($urandom_range(alpha) + 8'h41),
                      k == n - 1, 6'($urandom));
    endtask

    // wait for every expected word, then for the block's tail
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.awaited.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [6:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        board.set_reg(idx, val);
    endtask

    task automatic phase_cfg(logic [6:0] ent, logic [6:0] len, logic dup);
        drain();
        write_reg(CFG_ENTRIES, ent);
        write_reg(CFG_ENTRY_LEN, len);
        write_reg(CFG_ALLOW_DUP, {6'd0, dup});
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int total, pick;
        board = new();
        rst_n = 0; in_valid = 0; req_type = 0; char_code = 0; last_char = 0;
        rank = 0; cfg_valid = 0; cfg_index = 0; cfg_data = 0; out_ready = 0;
        calm = 0; words_sent = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, every request, the special cases
        send_word(REQ_READ, 8'h00, 1'b0, 6'd0);          // read of an empty table
        send_string(REQ_ADD, 1, 0);
        send_word(REQ_ADD, 8'h00, 1'b1, 6'd0);           // zero character
        send_word(REQ_ADD, 8'hFF, 1'b1, 6'd63);
        send_word(REQ_ADD, 8'hFF, 1'b1, 6'd0);           // duplicate
        send_string(REQ_ADD, 30, 0);                     // longest allowed
        send_string(REQ_ADD, 31, 0);                     // too long
        send_string(REQ_ADD, 34, 0);                     // past the pending buffer
        send_word(REQ_ADD, 8'hFF, 1'b0, 6'd0);           // mixed: remove decides
        send_word(REQ_REMOVE, 8'h00, 1'b0, 6'd0);
        send_word(REQ_CLEAR, 8'h00, 1'b0, 6'd0);         // clear keeps pending
        send_word(REQ_REMOVE, 8'h12, 1'b1, 6'd0);        // not found
        send_word(REQ_READ, 8'h00, 1'b1, 6'd63);
        send_word(REQ_REMOVE, 8'hFF, 1'b1, 6'd0);

        // sender holds off until every result is back
        drain();
        phase_cfg(7'd1, 7'd3, 1'b1);
        send_word(REQ_ADD, 8'h41, 1'b1, 6'd0);
        send_word(REQ_ADD, 8'h41, 1'b1, 6'd0);           // table full
        send_word(REQ_READ, 8'h00, 1'b0, 6'd0);
        send_word(REQ_ADD, 8'h41, 1'b0, 6'd0);
        send_word(REQ_ADD, 8'h41, 1'b1, 6'd0);           // table full, reported ahead of too long
        send_word(REQ_CLEAR, 8'h00, 1'b1, 6'd0);

        total = words_sent;
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: phase_cfg(7'd8, 7'd6, 1'b0);
                1: phase_cfg(7'd127, 7'd63, 1'b1);
                2: phase_cfg(7'd0, 7'd2, 1'b0);
                3: phase_cfg(7'd64, 7'd32, 1'b1);
                4: phase_cfg(7'd20, 7'd10, 1'b0);
                default: phase_cfg(7'd64, 7'd32, 1'b0);
            endcase
            calm = (ph == 3);
            while (words_sent < total + 50 * (ph + 1)) begin
                pick = $urandom_range(99);
                if (pick < 45) send_string(REQ_ADD, $urandom_range(4, 1), 3);
                else if (pick < 65) send_string(REQ_REMOVE, $urandom_range(4, 1), 3);
                else if (pick < 72) send_string(REQ_ADD, $urandom_range(34, 1), 0);
                else if (pick < 74) send_word(REQ_CLEAR, 8'($urandom), 1'($urandom),
                                              6'($urandom));
                else if (pick < 80) send_word(REQ_ADD, 8'($urandom), 1'b0, 6'($urandom));
                else send_word(REQ_READ, 8'($urandom), 1'($urandom),
                               6'($urandom_range(board.count + 1)));
            end
        end
        calm = 0;
        drain();
        if (board.errors == 0 && board.awaited.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
